>>> src/asfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfc_pkg: airspeed sensor frame converter shared definitions
// Fixed-point constants, register codes and pipeline sideband types used by
// the converter pipeline.
// ----------------------------------------------------------------------------
package asfc_pkg;

  // configuration register codes
  typedef enum logic [0:0] {
    CFG_PRESS_MIN = 1'b0,
    CFG_PRESS_MAX = 1'b1
  } cfg_reg_e;

  localparam int unsigned CFG_W = 18;

  localparam logic signed [CFG_W-1:0] PRESS_MIN_RST = -18'sd1000;
  localparam logic signed [CFG_W-1:0] PRESS_MAX_RST = 18'sd1000;

  // transfer function: 10 * count - full count, scaled limits
  localparam logic [18:0] FULL_COUNT = 19'd16383;
  localparam logic [16:0] SPAN_DEN   = 17'd131064;

  // pressure quotient: Q = floor(mag * PA_NUM / P512_DEN)
  localparam logic [22:0] PA_NUM     = 23'd6894757;
  localparam logic [27:0] P512_DEN   = 28'd255984375;
  // floor(2^37 * PA_NUM / P512_DEN), underestimates Q by at most one
  localparam logic [31:0] Q_RECIP    = 32'd3701820419;
  localparam int unsigned Q_SHIFT    = 37;
  // rounding thresholds on the remainder
  localparam logic [29:0] P512_FULL  = 30'd255984375;
  localparam logic [29:0] P512_HALF  = 30'd127992188;
  localparam logic [29:0] P512_TOP   = 30'd383976563;
  // pascals are the 1/512 Pa quotient rounded, so add half of 512
  localparam logic [29:0] PA_ROUND   = 30'd256;

  // airspeed: 49 * (2n-1)^2 <= 6250 * p512
  localparam logic [12:0] SPEED_W    = 13'd6250;
  localparam logic [21:0] DIV7_RECIP = 22'd2396746;
  localparam int unsigned DIV7_SHIFT = 24;
  localparam logic [17:0] SPEED_MAX  = 18'd131071;

  // square root of the radicand, one result bit per stage
  localparam int unsigned SQRT_W = 21;
  localparam int unsigned REM_W  = SQRT_W + 1;
  localparam int unsigned RAD_W  = 2 * SQRT_W;

  // temperature: round(20000 * dt / 2047) - 5000
  localparam logic [14:0] TEMP_SCALE  = 15'd20000;
  localparam logic [10:0] TEMP_BIAS   = 11'd1023;
  localparam logic [26:0] TEMP_RECIP  = 27'd67141649;
  localparam int unsigned TEMP_SHIFT  = 37;
  localparam logic [14:0] TEMP_OFFSET = 15'd5000;

  // register stages from request to result
  localparam int unsigned PIPE_DEPTH = 13 + SQRT_W;

  // sideband carried beside the pressure arithmetic
  typedef struct packed {
    logic [1:0]         status;
    logic               pos;
    logic signed [14:0] temp;
  } side_t;

  // sideband carried beside the square root
  typedef struct packed {
    logic [1:0]         status;
    logic               pos;
    logic signed [23:0] pa;
    logic signed [14:0] temp;
  } spd_side_t;

endpackage

>>> src/airspeed_sensor_frame_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// airspeed_sensor_frame_convert: differential-pressure sensor frame converter
// Unpacks one raw sensor frame and returns status, pressure in pascals,
// signed indicated airspeed in cm/s and temperature in 1/100 degree C.
// ----------------------------------------------------------------------------
// A new frame can be requested on every clock cycle: busy is never raised.
// Each request produces exactly one result, marked by done_o for one cycle,
// in request order, once it has passed through every pipeline register.
// The pipeline holds the 21-stage square root (one root bit per stage)
// plus 13 stages of scaling, reciprocal division and rounding. The pressure
// limits may only be rewritten while no request is in flight.
module airspeed_sensor_frame_convert (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [31:0]               raw_frame_i,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [asfc_pkg::CFG_W-1:0] cfg_wdata_i,
  output logic                      done_o,
  output logic [1:0]                sensor_status_o,
  output logic signed [23:0]        pressure_pa_o,
  output logic signed [17:0]        airspeed_cm_s_o,
  output logic signed [14:0]        temperature_centi_c_o
);
  import asfc_pkg::*;

  // the pipeline never stalls
  assign busy = 1'b0;

  logic in_acc;
  assign in_acc = start && !busy;

  // configuration registers
  logic signed [CFG_W-1:0] pmin_q, pmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmin_q <= PRESS_MIN_RST;
      pmax_q <= PRESS_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_PRESS_MIN: pmin_q <= $signed(cfg_wdata_i);
        CFG_PRESS_MAX: pmax_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // stage 1: unpack, count offset, span, scaled minimum and temperature scaling
  logic               s1_vld_q;
  logic [1:0]         s1_status_q;
  logic signed [18:0] s1_d_q, s1_d_d;
  logic signed [18:0] s1_span_q, s1_span_d;
  logic signed [35:0] s1_pbase_q, s1_pbase_d;
  logic [25:0]        s1_tx_q, s1_tx_d;
  logic [18:0]        s1_dp10;

  always_comb begin
    s1_dp10    = 19'(raw_frame_i[29:16]) * 19'd10;
    s1_d_d     = $signed(s1_dp10 - FULL_COUNT);
    s1_span_d  = 19'(pmax_q) - 19'(pmin_q);
    s1_pbase_d = 36'(pmin_q) * $signed(36'(SPAN_DEN));
    s1_tx_d    = 26'(raw_frame_i[15:5]) * 26'(TEMP_SCALE) + 26'(TEMP_BIAS);
  end

  always_ff @(posedge clk_i) begin
    s1_status_q <= raw_frame_i[31:30];
    s1_d_q      <= s1_d_d;
    s1_span_q   <= s1_span_d;
    s1_pbase_q  <= s1_pbase_d;
    s1_tx_q     <= s1_tx_d;
  end

  // stage 2: span product, temperature reciprocal division
  logic               s2_vld_q;
  logic [1:0]         s2_status_q;
  logic signed [37:0] s2_prod_q, s2_prod_d;
  logic signed [35:0] s2_pbase_q;
  logic [14:0]        s2_tq_q;
  logic [52:0]        s2_tprod;

  always_comb begin
    s2_prod_d = 38'(s1_d_q) * 38'(s1_span_q);
    s2_tprod  = 53'(s1_tx_q) * 53'(TEMP_RECIP);
  end

  always_ff @(posedge clk_i) begin
    s2_status_q <= s1_status_q;
    s2_prod_q   <= s2_prod_d;
    s2_pbase_q  <= s1_pbase_q;
    s2_tq_q     <= s2_tprod[TEMP_SHIFT+14:TEMP_SHIFT];
  end

  // stage 3: pressure numerator and temperature offset
  logic               s3_vld_q;
  logic [1:0]         s3_status_q;
  logic signed [35:0] s3_m_q;
  logic signed [14:0] s3_temp_q;
  logic signed [37:0] s3_sum;

  assign s3_sum = s2_prod_q + 38'(s2_pbase_q);

  always_ff @(posedge clk_i) begin
    s3_status_q <= s2_status_q;
    s3_m_q      <= $signed(s3_sum[35:0]);
    s3_temp_q   <= $signed(s2_tq_q - TEMP_OFFSET);
  end

  // stage 4: magnitude and sign (negative numerator means positive pressure)
  logic        s4_vld_q;
  side_t       s4_side_q;
  logic [34:0] s4_mag_q;

  always_ff @(posedge clk_i) begin
    s4_side_q.status <= s3_status_q;
    s4_side_q.pos    <= s3_m_q[35];
    s4_side_q.temp   <= s3_temp_q;
    s4_mag_q         <= 35'(s3_m_q[35] ? -s3_m_q : s3_m_q);
  end

  // stage 5: quotient estimate, partial products
  logic        s5_vld_q;
  side_t       s5_side_q;
  logic [49:0] s5_plo_q;
  logic [48:0] s5_phi_q;
  logic [29:0] s5_mag_q;

  always_ff @(posedge clk_i) begin
    s5_side_q <= s4_side_q;
    s5_plo_q  <= 50'(s4_mag_q[17:0]) * 50'(Q_RECIP);
    s5_phi_q  <= 49'(s4_mag_q[34:18]) * 49'(Q_RECIP);
    s5_mag_q  <= s4_mag_q[29:0];
  end

  // stage 6: quotient estimate, sum and shift
  logic        s6_vld_q;
  side_t       s6_side_q;
  logic [29:0] s6_q0_q;
  logic [29:0] s6_mag_q;
  logic [66:0] s6_sum;

  assign s6_sum = 67'({s5_phi_q, 18'b0}) + 67'(s5_plo_q);

  always_ff @(posedge clk_i) begin
    s6_side_q <= s5_side_q;
    s6_q0_q   <= s6_sum[Q_SHIFT+29:Q_SHIFT];
    s6_mag_q  <= s5_mag_q;
  end

  // stage 7: remainder terms, low bits only since the remainder is small
  logic        s7_vld_q;
  side_t       s7_side_q;
  logic [29:0] s7_ra_q, s7_rb_q, s7_q0_q;

  always_ff @(posedge clk_i) begin
    s7_side_q <= s6_side_q;
    s7_ra_q   <= s6_mag_q * 30'(PA_NUM);
    s7_rb_q   <= s6_q0_q * 30'(P512_DEN);
    s7_q0_q   <= s6_q0_q;
  end

  // stage 8: remainder
  logic        s8_vld_q;
  side_t       s8_side_q;
  logic [29:0] s8_r_q, s8_q0_q;

  always_ff @(posedge clk_i) begin
    s8_side_q <= s7_side_q;
    s8_r_q    <= s7_ra_q - s7_rb_q;
    s8_q0_q   <= s7_q0_q;
  end

  // stage 9: quotient correction and rounding compares
  logic        s9_vld_q;
  side_t       s9_side_q;
  logic [29:0] s9_q0_q;
  logic        s9_ge_half_q, s9_ge_full_q, s9_ge_top_q;

  always_ff @(posedge clk_i) begin
    s9_side_q    <= s8_side_q;
    s9_q0_q      <= s8_q0_q;
    s9_ge_half_q <= (s8_r_q >= P512_HALF);
    s9_ge_full_q <= (s8_r_q >= P512_FULL);
    s9_ge_top_q  <= (s8_r_q >= P512_TOP);
  end

  // stage 10: pressure in 1/512 Pa and in Pa, both rounded
  logic        s10_vld_q;
  side_t       s10_side_q;
  logic [29:0] s10_p512_q;
  logic [20:0] s10_pa_mag_q;
  logic [29:0] s10_pa_sum;

  assign s10_pa_sum = s9_q0_q + 30'(s9_ge_full_q) + PA_ROUND;

  always_ff @(posedge clk_i) begin
    s10_side_q   <= s9_side_q;
    s10_p512_q   <= s9_q0_q + 30'(s9_ge_half_q) + 30'(s9_ge_top_q);
    s10_pa_mag_q <= s10_pa_sum[29:9];
  end

  // square root pipeline; index 0 holds the radicand and signed pressure
  logic            sq_vld_q  [0:SQRT_W];
  logic [RAD_W-1:0] sq_w_q    [0:SQRT_W];
  spd_side_t       sq_side_q [0:SQRT_W];
  logic [REM_W-1:0] sq_rem_q  [1:SQRT_W];
  logic [SQRT_W-1:0] sq_root_q [1:SQRT_W];

  always_ff @(posedge clk_i) begin
    sq_w_q[0]           <= RAD_W'(s10_p512_q) * RAD_W'(SPEED_W);
    sq_side_q[0].status <= s10_side_q.status;
    sq_side_q[0].pos    <= s10_side_q.pos;
    sq_side_q[0].temp   <= s10_side_q.temp;
    sq_side_q[0].pa     <= s10_side_q.pos ? $signed({3'b0, s10_pa_mag_q})
                                          : -$signed({3'b0, s10_pa_mag_q});
  end

  for (genvar g = 0; g < SQRT_W; g++) begin : g_sqrt
    logic [REM_W-1:0]  rem_prev;
    logic [SQRT_W-1:0] root_prev;
    logic [REM_W+1:0]  work;
    logic [REM_W+1:0]  trial;

    if (g == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
    end else begin : g_rest
      assign rem_prev  = sq_rem_q[g];
      assign root_prev = sq_root_q[g];
    end

    // one restoring step: bring in two radicand bits, try root bit one
    assign work  = {rem_prev, sq_w_q[g][2*(SQRT_W-1-g)+1 -: 2]};
    assign trial = {1'b0, root_prev, 2'b01};

    always_ff @(posedge clk_i) begin
      sq_w_q[g+1]    <= sq_w_q[g];
      sq_side_q[g+1] <= sq_side_q[g];
      if (work >= trial) begin
        sq_rem_q[g+1]  <= REM_W'(work - trial);
        sq_root_q[g+1] <= {root_prev[SQRT_W-2:0], 1'b1};
      end else begin
        sq_rem_q[g+1]  <= REM_W'(work);
        sq_root_q[g+1] <= {root_prev[SQRT_W-2:0], 1'b0};
      end
    end
  end

  // divide the root by seven
  logic            dv_vld_q;
  spd_side_t       dv_side_q;
  logic [18:0]     dv_h_q;
  logic [SQRT_W+21:0] dv_prod;

  assign dv_prod = (SQRT_W+22)'(sq_root_q[SQRT_W]) * (SQRT_W+22)'(DIV7_RECIP);

  always_ff @(posedge clk_i) begin
    dv_side_q <= sq_side_q[SQRT_W];
    dv_h_q    <= dv_prod[DIV7_SHIFT+18:DIV7_SHIFT];
  end

  // speed magnitude, saturation and sign, then the result register
  logic        out_vld_q;
  logic [19:0] fin_sum;
  logic [18:0] fin_n;
  logic [17:0] fin_sat;

  always_comb begin
    fin_sum = 20'(dv_h_q) + 20'd1;
    fin_n   = fin_sum[19:1];
    fin_sat = (fin_n > 19'(SPEED_MAX)) ? SPEED_MAX : fin_n[17:0];
  end

  always_ff @(posedge clk_i) begin
    sensor_status_o       <= dv_side_q.status;
    pressure_pa_o         <= dv_side_q.pa;
    temperature_centi_c_o <= dv_side_q.temp;
    airspeed_cm_s_o       <= $signed(dv_side_q.pos ? fin_sat : 18'(-fin_sat));
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      for (int i = 0; i <= SQRT_W; i++) begin
        sq_vld_q[i] <= 1'b0;
      end
      dv_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q    <= in_acc;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      s4_vld_q    <= s3_vld_q;
      s5_vld_q    <= s4_vld_q;
      s6_vld_q    <= s5_vld_q;
      s7_vld_q    <= s6_vld_q;
      s8_vld_q    <= s7_vld_q;
      s9_vld_q    <= s8_vld_q;
      s10_vld_q   <= s9_vld_q;
      sq_vld_q[0] <= s10_vld_q;
      for (int i = 0; i < SQRT_W; i++) begin
        sq_vld_q[i+1] <= sq_vld_q[i];
      end
      dv_vld_q  <= sq_vld_q[SQRT_W];
      out_vld_q <= dv_vld_q;
    end
  end

  assign done_o = out_vld_q;

`ifndef NO_ASSERTIONS
  // every request comes out after the fixed latency
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##PIPE_DEPTH done_o)
    else $error("request did not produce a result after the pipeline latency");

  // no result without a request at the matching earlier edge
  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_acc, PIPE_DEPTH))
    else $error("result strobe without a matching request");

  // airspeed sign follows the pressure sign
  a_speed_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (airspeed_cm_s_o != 18'sd0) |->
      (airspeed_cm_s_o[17] == pressure_pa_o[23]) || (pressure_pa_o == 24'sd0))
    else $error("airspeed sign disagrees with pressure sign");

  // temperature stays within the sensor scale
  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (temperature_centi_c_o >= -15'sd5000) &&
               (temperature_centi_c_o <= 15'sd15000))
    else $error("temperature outside the sensor scale");
`endif

endmodule
